@@ rtl/crt_pkg.sv @@
// crt_pkg: constants and operation codes for the circular range add / min tree
// no dependencies
`timescale 1ns / 1ps

package crt_pkg;

    localparam int CRT_IW           = 11;
    localparam int CRT_VW           = 64;
    localparam int CRT_PAW          = 3;
    localparam int CRT_MAX_ELEMENTS = 1024;

    localparam logic [CRT_IW-1:0] CRT_ELEMS_RESET = 11'd1024;

    localparam logic [CRT_VW-1:0] CRT_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [CRT_VW-1:0] CRT_NEG_MIN = 64'h8000_0000_0000_0000;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MIN = 1'b1;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_ELEMS = 1'b0;

endpackage

@@ rtl/crt_alu.sv @@
// crt_alu: shared 64-bit saturating adder and signed minimum unit
// depends on crt_pkg
`timescale 1ns / 1ps

module crt_alu import crt_pkg::*; (
    input  logic              i_op,
    input  logic [CRT_VW-1:0] i_a,
    input  logic [CRT_VW-1:0] i_b,
    output logic [CRT_VW-1:0] o_y
);

    logic [CRT_VW-1:0] sum;
    logic              ovf;

    always_comb begin
        sum = i_a + i_b;
        ovf = (i_a[CRT_VW-1] == i_b[CRT_VW-1]) && (sum[CRT_VW-1] != i_a[CRT_VW-1]);
        case (i_op)
            OP_ADD: begin
                if (ovf) begin
                    o_y = i_a[CRT_VW-1] ? CRT_NEG_MIN : CRT_POS_MAX;
                end else begin
                    o_y = sum;
                end
            end
            OP_MIN: begin
                o_y = ($signed(i_a) < $signed(i_b)) ? i_a : i_b;
            end
            default: begin
                o_y = i_a;
            end
        endcase
    end

endmodule

@@ rtl/crt_ram.sv @@
// crt_ram: single write port, single read port memory with registered read
// no dependencies
`timescale 1ns / 1ps

module crt_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/circular_range_add_min_tree_top.sv @@
// circular_range_add_min_tree_top: lazy segment tree sequencer, config port, result register
// depends on crt_pkg, crt_alu, crt_ram
// sequence: each visited node passes S_ENTER, S_SET (S_OWE1/2 push a pending add down), S_DEC;
// each return passes S_RET; an add rebuilds each split node in S_PM1 to S_PM3 on the way back
// throughput: one request at a time, twice the passes for a wrapped range; not ready meanwhile
// reset: synchronous; a clearing pass zeroes both memories, stall high
`timescale 1ns / 1ps

module circular_range_add_min_tree_top import crt_pkg::*; #(
    parameter int TREE_NODES = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_cmd,
    input  logic [9:0]          i_left_index,
    input  logic [9:0]          i_right_index,
    input  logic signed [31:0]  i_add_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [63:0]  o_min_value,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CRT_PAW-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW  = $clog2(TREE_NODES);
    localparam int NW  = AW + 2;
    localparam int SD  = AW + 2;
    localparam int SIW = $clog2(SD);
    localparam int SPW = $clog2(SD + 1);
    localparam int IW  = CRT_IW;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ENTER = 4'd2;
    localparam logic [3:0] S_SET   = 4'd3;
    localparam logic [3:0] S_OWE1  = 4'd4;
    localparam logic [3:0] S_OWE2  = 4'd5;
    localparam logic [3:0] S_DEC   = 4'd6;
    localparam logic [3:0] S_RET   = 4'd7;
    localparam logic [3:0] S_PM1   = 4'd8;
    localparam logic [3:0] S_PM2   = 4'd9;
    localparam logic [3:0] S_PM3   = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    localparam logic AFT_DEC = 1'b0;
    localparam logic AFT_RET = 1'b1;

    typedef struct packed {
        logic [NW-1:0]     node;
        logic [IW-1:0]     lo;
        logic [IW-1:0]     hi;
        logic [IW-1:0]     ql;
        logic [IW-1:0]     qr;
        logic              side;
        logic [CRT_VW-1:0] acc;
    } t_frame;

    logic [3:0]        r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [IW-1:0]     r_elems, n_elems;
    logic              r_cmd, n_cmd;
    logic [IW-1:0]     r_l, n_l;
    logic [CRT_VW-1:0] r_v, n_v;
    logic              r_wrap, n_wrap;
    logic              r_second, n_second;
    t_frame            r_cur, n_cur;
    logic [CRT_VW-1:0] r_m, n_m;
    logic [CRT_VW-1:0] r_p, n_p;
    logic              r_after, n_after;
    logic [CRT_VW-1:0] r_ret, n_ret;
    logic [CRT_VW-1:0] r_res, n_res;
    logic [SPW-1:0]    r_sp, n_sp;
    t_frame            r_stk [SD];
    logic              r_ovalid, n_ovalid;
    logic [CRT_VW-1:0] r_omin, n_omin;

    logic              min_we, lazy_we;
    logic [AW-1:0]     min_waddr, lazy_waddr, min_raddr, lazy_raddr;
    logic [CRT_VW-1:0] min_wdata, lazy_wdata, min_rdata, lazy_rdata;
    logic              alu_op;
    logic [CRT_VW-1:0] alu_a, alu_b, alu_y;
    logic              stk_we;
    logic [SIW-1:0]    stk_idx;
    t_frame            stk_wdata;

    logic [SPW-1:0]    sp_m1;
    t_frame            top;
    logic [NW-1:0]     c1, c2, tc2;
    logic              cur_ok, c1_ok, c2_ok;
    logic [IW-1:0]     mid, tmid, last;
    logic [IW-1:0]     in_l, in_r;
    logic              cfg_wr;
    logic [IW-1:0]     wval;

    crt_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    crt_ram #(.DEPTH(TREE_NODES), .WIDTH(CRT_VW)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (min_we),
        .i_waddr (min_waddr),
        .i_wdata (min_wdata),
        .i_raddr (min_raddr),
        .o_rdata (min_rdata)
    );

    crt_ram #(.DEPTH(TREE_NODES), .WIDTH(CRT_VW)) u_lazy_ram (
        .i_clk   (i_clk),
        .i_we    (lazy_we),
        .i_waddr (lazy_waddr),
        .i_wdata (lazy_wdata),
        .i_raddr (lazy_raddr),
        .o_rdata (lazy_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_min_value = r_omin;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_ELEMS) ? {{(32-IW){1'b0}}, r_elems} : 32'd0;

    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ELEMS);
    assign wval   = pwdata[IW-1:0];

    assign sp_m1  = r_sp - SPW'(1);
    assign top    = r_stk[sp_m1[SIW-1:0]];
    assign c1     = {r_cur.node[NW-2:0], 1'b0} + NW'(1);
    assign c2     = {r_cur.node[NW-2:0], 1'b0} + NW'(2);
    assign tc2    = {top.node[NW-2:0], 1'b0} + NW'(2);
    assign cur_ok = r_cur.node < NW'(TREE_NODES);
    assign c1_ok  = c1 < NW'(TREE_NODES);
    assign c2_ok  = c2 < NW'(TREE_NODES);
    assign mid    = IW'(({1'b0, r_cur.lo} + {1'b0, r_cur.hi}) >> 1);
    assign tmid   = IW'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);
    assign last   = r_elems - IW'(1);
    assign in_l   = IW'(i_left_index);
    assign in_r   = IW'(i_right_index);

    always_comb begin
        n_elems = r_elems;
        if (cfg_wr) begin
            if (wval == '0) begin
                n_elems = IW'(1);
            end else if (32'(wval) > 32'(CRT_MAX_ELEMENTS)) begin
                n_elems = IW'(CRT_MAX_ELEMENTS);
            end else begin
                n_elems = wval;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_cmd    = r_cmd;
        n_l      = r_l;
        n_v      = r_v;
        n_wrap   = r_wrap;
        n_second = r_second;
        n_cur    = r_cur;
        n_m      = r_m;
        n_p      = r_p;
        n_after  = r_after;
        n_ret    = r_ret;
        n_res    = r_res;
        n_sp     = r_sp;
        n_ovalid = r_ovalid && i_out_stall;
        n_omin   = r_omin;

        min_we     = 1'b0;
        min_waddr  = r_cur.node[AW-1:0];
        min_wdata  = alu_y;
        min_raddr  = r_cur.node[AW-1:0];
        lazy_we    = 1'b0;
        lazy_waddr = r_cur.node[AW-1:0];
        lazy_wdata = alu_y;
        lazy_raddr = r_cur.node[AW-1:0];
        alu_op     = OP_ADD;
        alu_a      = r_m;
        alu_b      = r_p;
        stk_we     = 1'b0;
        stk_idx    = r_sp[SIW-1:0];
        stk_wdata  = r_cur;

        case (r_state)
            S_CLR: begin
                min_we     = 1'b1;
                min_waddr  = r_clr;
                min_wdata  = '0;
                lazy_we    = 1'b1;
                lazy_waddr = r_clr;
                lazy_wdata = '0;
                if (r_clr == AW'(TREE_NODES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid && (in_l < r_elems) && (in_r < r_elems)) begin
                    n_cmd    = i_cmd;
                    n_l      = in_l;
                    n_v      = CRT_VW'(signed'(i_add_value));
                    n_wrap   = in_l > in_r;
                    n_second = 1'b0;
                    n_sp     = '0;
                    n_cur    = '0;
                    n_cur.hi = last;
                    n_cur.ql = (in_l > in_r) ? '0 : in_l;
                    n_cur.qr = in_r;
                    n_state  = S_ENTER;
                end
            end
            S_ENTER: begin
                if (!cur_ok) begin
                    n_ret   = CRT_POS_MAX;
                    n_state = S_RET;
                end else begin
                    n_state = S_SET;
                end
            end
            S_SET: begin
                alu_a = min_rdata;
                alu_b = lazy_rdata;
                if (lazy_rdata == '0) begin
                    n_m     = min_rdata;
                    n_state = S_DEC;
                end else begin
                    min_we     = 1'b1;
                    lazy_we    = 1'b1;
                    lazy_wdata = '0;
                    n_m        = alu_y;
                    n_p        = lazy_rdata;
                    if (r_cur.lo != r_cur.hi) begin
                        lazy_raddr = c1[AW-1:0];
                        n_after    = AFT_DEC;
                        n_state    = S_OWE1;
                    end else begin
                        n_state = S_DEC;
                    end
                end
            end
            S_OWE1: begin
                alu_a      = lazy_rdata;
                alu_b      = r_p;
                lazy_we    = c1_ok;
                lazy_waddr = c1[AW-1:0];
                lazy_raddr = c2[AW-1:0];
                n_state    = S_OWE2;
            end
            S_OWE2: begin
                alu_a      = lazy_rdata;
                alu_b      = r_p;
                lazy_we    = c2_ok;
                lazy_waddr = c2[AW-1:0];
                n_state    = (r_after == AFT_DEC) ? S_DEC : S_RET;
            end
            S_DEC: begin
                if ((r_cur.ql > r_cur.hi) || (r_cur.qr < r_cur.lo)) begin
                    n_ret   = CRT_POS_MAX;
                    n_state = S_RET;
                end else if ((r_cmd == CMD_ADD) && (r_cur.lo >= r_cur.ql)
                             && (r_cur.hi <= r_cur.qr)) begin
                    alu_a  = r_m;
                    alu_b  = r_v;
                    min_we = 1'b1;
                    if (r_cur.lo != r_cur.hi) begin
                        n_p        = r_v;
                        lazy_raddr = c1[AW-1:0];
                        n_after    = AFT_RET;
                        n_state    = S_OWE1;
                    end else begin
                        n_state = S_RET;
                    end
                end else if ((r_cmd == CMD_QUERY) && (r_cur.ql == r_cur.lo)
                             && (r_cur.qr == r_cur.hi)) begin
                    n_ret   = r_m;
                    n_state = S_RET;
                end else begin
                    stk_we         = 1'b1;
                    stk_wdata      = r_cur;
                    stk_wdata.side = 1'b0;
                    n_sp           = r_sp + SPW'(1);
                    n_cur.node     = c1;
                    n_cur.hi       = mid;
                    n_cur.side     = 1'b0;
                    if ((r_cmd == CMD_QUERY) && (r_cur.qr > mid)) begin
                        n_cur.qr = mid;
                    end
                    n_state = S_ENTER;
                end
            end
            S_RET: begin
                if (r_sp == '0) begin
                    if (r_wrap && !r_second) begin
                        n_res    = r_ret;
                        n_second = 1'b1;
                        n_cur    = '0;
                        n_cur.hi = last;
                        n_cur.ql = r_l;
                        n_cur.qr = last;
                        n_state  = S_ENTER;
                    end else if (r_cmd == CMD_QUERY) begin
                        alu_op  = OP_MIN;
                        alu_a   = r_res;
                        alu_b   = r_ret;
                        n_ret   = r_second ? alu_y : r_ret;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (top.side == 1'b0) begin
                    stk_we         = 1'b1;
                    stk_idx        = sp_m1[SIW-1:0];
                    stk_wdata      = top;
                    stk_wdata.side = 1'b1;
                    stk_wdata.acc  = r_ret;
                    n_cur          = top;
                    n_cur.node     = tc2;
                    n_cur.lo       = tmid + IW'(1);
                    n_cur.side     = 1'b0;
                    if ((r_cmd == CMD_QUERY) && (top.ql < tmid + IW'(1))) begin
                        n_cur.ql = tmid + IW'(1);
                    end
                    n_state = S_ENTER;
                end else begin
                    n_sp  = sp_m1;
                    n_cur = top;
                    if (r_cmd == CMD_ADD) begin
                        n_state = S_PM1;
                    end else begin
                        alu_op = OP_MIN;
                        alu_a  = top.acc;
                        alu_b  = r_ret;
                        n_ret  = alu_y;
                    end
                end
            end
            S_PM1: begin
                min_raddr = c1[AW-1:0];
                n_state   = S_PM2;
            end
            S_PM2: begin
                n_m       = c1_ok ? min_rdata : CRT_POS_MAX;
                min_raddr = c2[AW-1:0];
                n_state   = S_PM3;
            end
            S_PM3: begin
                alu_op  = OP_MIN;
                alu_a   = r_m;
                alu_b   = c2_ok ? min_rdata : CRT_POS_MAX;
                min_we  = 1'b1;
                n_state = S_RET;
            end
            S_FIN: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_omin   = r_ret;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_elems  <= CRT_ELEMS_RESET;
            r_sp     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_elems  <= n_elems;
            r_sp     <= n_sp;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_l      <= n_l;
        r_v      <= n_v;
        r_wrap   <= n_wrap;
        r_second <= n_second;
        r_cur    <= n_cur;
        r_m      <= n_m;
        r_p      <= n_p;
        r_after  <= n_after;
        r_ret    <= n_ret;
        r_res    <= n_res;
        r_omin   <= n_omin;
        if (stk_we) begin
            r_stk[stk_idx] <= stk_wdata;
        end
    end

endmodule

@@ rtl/crt_chk.sv @@
// crt_chk: port-level checks for the circular range add / min tree, bound to the top level
// depends on circular_range_add_min_tree_top
`timescale 1ns / 1ps

module crt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [63:0] o_min_value,
    input logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_min_value))
        else $error("result changed while stalled");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_in_stall)
        else $error("request taken during clearing pass");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("result right after request");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind circular_range_add_min_tree_top crt_chk u_crt_chk (.*);
